/* src/dtws_pkg.sv */
`timescale 1ns / 1ps

package dtws_pkg;

  localparam int unsigned TimerWidthDef = 16;

  localparam int unsigned TickW  = 15;
  localparam int unsigned AngleW = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    CMD_POLL  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_e;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_COOLDOWN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OPEN_ANG = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CLOS_ANG = 3'd4;

  localparam logic [TickW-1:0]  DebounceRst  = 15'd300;
  localparam logic [TickW-1:0]  CooldownRst  = 15'd3000;
  localparam logic [TickW-1:0]  StepRst      = 15'd15;
  localparam logic [AngleW-1:0] OpenAngRst   = 8'd170;
  localparam logic [AngleW-1:0] ClosAngRst   = 8'd55;
  localparam logic [AngleW-1:0] AngleRst     = 8'd60;

  typedef struct packed {
    logic [TickW-1:0]  debounce_ticks;
    logic [TickW-1:0]  cooldown_ticks;
    logic [TickW-1:0]  step_ticks;
    logic [AngleW-1:0] open_angle;
    logic [AngleW-1:0] closed_angle;
  } cfg_t;

  typedef struct packed {
    logic [AngleW-1:0] servo_angle;
    logic              door_open;
    logic              state_changed;
  } result_t;

endpackage

/* src/door_toggle_with_servo_slew.sv */
`timescale 1ns / 1ps

// Door toggle controller with one-degree servo slew. Each command beat is
// registered, evaluated combinationally against the door state, and its result
// beat lands in an output register, so one beat per cycle is sustained while
// the result side takes beats; an accepted beat passes the input register and
// then the result register, and can wait in the input register while the result
// side stalls. Input ready follows output ready through the single result
// register; no stall occurs while the result side keeps taking beats. The since_*
// tick counters are TimerWidth bits wide and saturate. Write configuration only while no beat is in flight.
module door_toggle_with_servo_slew #(
  parameter int unsigned TimerWidth = dtws_pkg::TimerWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic                          button_level_i,
  input  logic                          card_seen_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dtws_pkg::AngleW-1:0]   servo_angle_o,
  output logic                          door_open_o,
  output logic                          state_changed_o,
  input  logic                          cfg_we_i,
  input  logic [dtws_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dtws_pkg::TickW-1:0]    cfg_wdata_i
);

  dtws_pkg::cfg_t    cfg;
  dtws_pkg::result_t res, res_q;

  logic       in_vld_q, out_vld_q, adv;
  logic [1:0] cmd_q;
  logic       level_q, card_q;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q   <= command_i;
      level_q <= button_level_i;
      card_q  <= card_seen_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  dtws_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dtws_core #(
    .TimerWidth (TimerWidth)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .command_i      (cmd_q),
    .button_level_i (level_q),
    .card_seen_i    (card_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  assign out_valid_o     = out_vld_q;
  assign servo_angle_o   = res_q.servo_angle;
  assign door_open_o     = res_q.door_open;
  assign state_changed_o = res_q.state_changed;

endmodule

/* src/dtws_cfg.sv */
`timescale 1ns / 1ps

module dtws_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dtws_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dtws_pkg::TickW-1:0]    cfg_wdata_i,
  output dtws_pkg::cfg_t                cfg_o
);

  dtws_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        dtws_pkg::CFG_DEBOUNCE: cfg_d.debounce_ticks = cfg_wdata_i;
        dtws_pkg::CFG_COOLDOWN: cfg_d.cooldown_ticks = cfg_wdata_i;
        dtws_pkg::CFG_STEP:     cfg_d.step_ticks     = cfg_wdata_i;
        dtws_pkg::CFG_OPEN_ANG: cfg_d.open_angle     = cfg_wdata_i[dtws_pkg::AngleW-1:0];
        dtws_pkg::CFG_CLOS_ANG: cfg_d.closed_angle   = cfg_wdata_i[dtws_pkg::AngleW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= dtws_pkg::DebounceRst;
      cfg_q.cooldown_ticks <= dtws_pkg::CooldownRst;
      cfg_q.step_ticks     <= dtws_pkg::StepRst;
      cfg_q.open_angle     <= dtws_pkg::OpenAngRst;
      cfg_q.closed_angle   <= dtws_pkg::ClosAngRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/dtws_core.sv */
`timescale 1ns / 1ps

module dtws_core #(
  parameter int unsigned TimerWidth = dtws_pkg::TimerWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic [1:0]           command_i,
  input  logic                 button_level_i,
  input  logic                 card_seen_i,
  input  dtws_pkg::cfg_t       cfg_i,
  output dtws_pkg::result_t    res_o
);

  localparam int unsigned CmpW = (TimerWidth > dtws_pkg::TickW) ? TimerWidth : dtws_pkg::TickW;

  logic [dtws_pkg::AngleW-1:0] angle_now_q, angle_now_d;
  logic [dtws_pkg::AngleW-1:0] angle_goal_q, angle_goal_d;
  logic                        open_q, open_d;
  logic                        prev_btn_q, prev_btn_d;
  logic [TimerWidth-1:0]       since_step_q, since_step_d;
  logic [TimerWidth-1:0]       since_press_q, since_press_d;
  logic [TimerWidth-1:0]       since_act_q, since_act_d;

  logic [TimerWidth-1:0] step_inc, press_inc, act_inc;
  logic                  step_hit, press_ok, toggle, changed;

  assign step_inc  = (&since_step_q)  ? since_step_q  : since_step_q  + 1'b1;
  assign press_inc = (&since_press_q) ? since_press_q : since_press_q + 1'b1;
  assign act_inc   = (&since_act_q)   ? since_act_q   : since_act_q   + 1'b1;

  assign step_hit = CmpW'(step_inc) >= CmpW'(cfg_i.step_ticks);
  assign press_ok = !button_level_i && prev_btn_q
                    && (CmpW'(press_inc) > CmpW'(cfg_i.debounce_ticks));
  assign toggle   = (press_ok || card_seen_i)
                    && (CmpW'(act_inc) >= CmpW'(cfg_i.cooldown_ticks));

  always_comb begin
    angle_now_d   = angle_now_q;
    angle_goal_d  = angle_goal_q;
    open_d        = open_q;
    prev_btn_d    = prev_btn_q;
    since_step_d  = since_step_q;
    since_press_d = since_press_q;
    since_act_d   = since_act_q;
    changed       = 1'b0;
    case (dtws_pkg::cmd_e'(command_i))
      dtws_pkg::CMD_POLL: begin
        since_step_d  = step_hit ? '0 : step_inc;
        since_press_d = press_ok ? '0 : press_inc;
        since_act_d   = act_inc;
        prev_btn_d    = button_level_i;
        if (step_hit) begin
          if (angle_now_q < angle_goal_q) begin
            angle_now_d = angle_now_q + 1'b1;
          end else if (angle_now_q > angle_goal_q) begin
            angle_now_d = angle_now_q - 1'b1;
          end
        end
        if (toggle) begin
          open_d       = !open_q;
          angle_goal_d = open_q ? cfg_i.closed_angle : cfg_i.open_angle;
          since_act_d  = '0;
          changed      = 1'b1;
        end
      end
      dtws_pkg::CMD_OPEN: begin
        open_d       = 1'b1;
        angle_goal_d = cfg_i.open_angle;
        since_act_d  = '0;
      end
      dtws_pkg::CMD_CLOSE: begin
        open_d       = 1'b0;
        angle_goal_d = cfg_i.closed_angle;
        since_act_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_now_q   <= dtws_pkg::AngleRst;
      angle_goal_q  <= dtws_pkg::AngleRst;
      open_q        <= 1'b0;
      prev_btn_q    <= 1'b1;
      since_step_q  <= '0;
      since_press_q <= '0;
      since_act_q   <= '0;
    end else if (adv_i) begin
      angle_now_q   <= angle_now_d;
      angle_goal_q  <= angle_goal_d;
      open_q        <= open_d;
      prev_btn_q    <= prev_btn_d;
      since_step_q  <= since_step_d;
      since_press_q <= since_press_d;
      since_act_q   <= since_act_d;
    end
  end

  assign res_o.servo_angle   = angle_now_d;
  assign res_o.door_open     = open_d;
  assign res_o.state_changed = changed;

endmodule
